@@ rtl/core/kns_pkg.sv @@
`default_nettype none
package kns_pkg;
    localparam int FracBits = 28;
    localparam int MaxIter = 40;
    localparam int W = FracBits + 8;
    localparam int CordicIter = FracBits;
    localparam logic [27:0] EccReset = 28'd130746533;
    localparam logic [27:0] TolReset = 28'd268;
    localparam int IdxEcc = 0;
    localparam int IdxTol = 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_CORDIC, ST_MUL, ST_DIV, ST_UPDATE, ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic cordic_init;
        logic cordic_step;
        logic mul;
        logic div_init;
        logic div_step;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic cordic_done;
        logic div_done;
        logic conv;
    } sts_t;

    // atan(2^-i) in Q.28, rounded
    function automatic logic [31:0] atan_tab(input logic [5:0] i);
        logic [31:0] t;
        begin
            case (i)
                6'd0: t = 32'd210828714;
                6'd1: t = 32'd124459457;
                6'd2: t = 32'd65760959;
                6'd3: t = 32'd33381290;
                6'd4: t = 32'd16755422;
                6'd5: t = 32'd8385879;
                6'd6: t = 32'd4193963;
                6'd7: t = 32'd2097109;
                6'd8: t = 32'd1048571;
                6'd9: t = 32'd524287;
                6'd10: t = 32'd262144;
                6'd11: t = 32'd131072;
                6'd12: t = 32'd65536;
                6'd13: t = 32'd32768;
                6'd14: t = 32'd16384;
                6'd15: t = 32'd8192;
                6'd16: t = 32'd4096;
                6'd17: t = 32'd2048;
                6'd18: t = 32'd1024;
                6'd19: t = 32'd512;
                6'd20: t = 32'd256;
                6'd21: t = 32'd128;
                6'd22: t = 32'd64;
                6'd23: t = 32'd32;
                6'd24: t = 32'd16;
                6'd25: t = 32'd8;
                6'd26: t = 32'd4;
                6'd27: t = 32'd2;
                6'd28: t = 32'd1;
                6'd29: t = 32'd1;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

    localparam logic [31:0] PiQ = 32'd843314856;
    localparam logic [31:0] HalfPiQ = 32'd421657428;
    localparam logic [31:0] TwoPiQ = 32'd1686629713;
    localparam logic [31:0] GainQ = 32'd163008218;
endpackage
`default_nettype wire

@@ rtl/core/kepler_newton_solver_top.sv @@
// each Newton step runs range reduction, CORDIC rotation, multiply, divide and update in turn
// an item runs up to MAX_ITERATIONS Newton steps, 40 by default, and ends early once converged
// the radix-2 divider, one quotient bit per cycle, sets most of the step time
// one transaction at a time; busy stays high through the result strobe cycle
// reset (rst_n, async low) returns to idle and loads default eccentricity and tolerance
// results are flagged by done, high for a single cycle, and hold until the next start; the receiver cannot stall
`default_nettype none
module kepler_newton_solver_top #(
    parameter int MAX_ITERATIONS = kns_pkg::MaxIter
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [30:0] mean_anomaly,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [27:0] cfg_data,
    output logic             done,
    output logic [30:0]      eccentric_anomaly,
    output logic             converged,
    output logic [5:0]       iterations_used
);
    import kns_pkg::*;

    logic [27:0] ecc_reg, tol_reg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecc_reg <= EccReset;
            tol_reg <= TolReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(IdxEcc))
                ecc_reg <= cfg_data;
            else
                tol_reg <= cfg_data;
        end
    end

    kns_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cmd(cmd), .sts(sts), .iter_out(iterations_used), .conv_out(converged)
    );

    kns_datapath u_dp (
        .clk(clk), .cmd(cmd), .sts(sts), .m_in(mean_anomaly),
        .ecc(ecc_reg), .tol(tol_reg), .e_out(eccentric_anomaly)
    );
endmodule
`default_nettype wire

@@ rtl/core/kns_datapath.sv @@
`default_nettype none
module kns_datapath (
    input  wire logic                 clk,
    input  wire kns_pkg::cmd_t        cmd,
    output kns_pkg::sts_t             sts,
    input  wire logic [30:0]          m_in,
    input  wire logic [27:0]          ecc,
    input  wire logic [27:0]          tol,
    output logic [30:0]               e_out
);
    import kns_pkg::*;

    localparam logic signed [W-1:0] One = W'(64'sd1 <<< FracBits);
    localparam logic signed [W-1:0] Pi = W'(PiQ);
    localparam logic signed [W-1:0] HalfPi = W'(HalfPiQ);
    localparam logic signed [W-1:0] TwoPi = W'(TwoPiQ);
    localparam logic [W-1:0] Four = W'(64'd4 << FracBits);

    logic signed [W-1:0] m_reg, e_reg, a_reg, x_reg, y_reg, z_reg, f_reg, d_reg;
    logic flip_reg;
    logic [5:0] ci_reg;
    logic [W-1:0] num_reg, rem_reg, q_reg;
    logic [6:0] di_reg;
    logic ovf_reg, neg_reg, conv_reg;

    logic signed [W-1:0] xs, ys, atn;
    logic [59:0] ps, pc;
    logic [W-1:0] es_mag, ec_mag, abs_s, abs_c, sm, cm;
    logic signed [W-1:0] f_c, d_c, e_new, e_clamp, qs;
    logic [W:0] rem_sh;
    logic [W-1:0] qmag;

    assign xs = x_reg >>> ci_reg;
    assign ys = y_reg >>> ci_reg;
    assign atn = W'(atan_tab(ci_reg));

    assign abs_s = y_reg[W-1] ? W'(-y_reg) : W'(y_reg);
    assign abs_c = x_reg[W-1] ? W'(-x_reg) : W'(x_reg);
    // cordic outputs stay below 2^29 in magnitude
    assign ps = 60'(ecc) * 60'(abs_s[31:0]);
    assign pc = 60'(ecc) * 60'(abs_c[31:0]);
    assign es_mag = W'(ps >> FracBits);
    assign ec_mag = W'(pc >> FracBits);
    assign sm = y_reg[W-1] ? W'(-es_mag) : es_mag;
    assign cm = (x_reg[W-1] ^ flip_reg) ? W'(-ec_mag) : ec_mag;
    assign f_c = e_reg - $signed(sm) - m_reg;
    assign d_c = One - $signed(cm);

    assign rem_sh = {rem_reg, num_reg[W-1]};
    assign qmag = (ovf_reg || q_reg > Four) ? Four : q_reg;
    assign qs = neg_reg ? -$signed(qmag) : $signed(qmag);
    assign e_new = e_reg - qs;
    assign e_clamp = (e_new < m_reg - One) ? m_reg - One :
                     (e_new > m_reg + One) ? m_reg + One : e_new;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg <= W'(m_in);
            e_reg <= W'(m_in);
        end
        if (cmd.reduce)
        begin
            if (a_reg > Pi)
                a_reg <= a_reg - TwoPi;
            else if (a_reg < -Pi)
                a_reg <= a_reg + TwoPi;
            else if (a_reg > HalfPi)
            begin
                a_reg <= Pi - a_reg;
                flip_reg <= 1'b1;
            end
            else if (a_reg < -HalfPi)
            begin
                a_reg <= -Pi - a_reg;
                flip_reg <= 1'b1;
            end
        end
        if (cmd.cordic_init)
        begin
            x_reg <= W'(GainQ);
            y_reg <= '0;
            z_reg <= a_reg;
            ci_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atn;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atn;
            end
            ci_reg <= ci_reg + 6'd1;
        end
        if (cmd.mul)
        begin
            f_reg <= f_c;
            d_reg <= (d_c < 1) ? W'(1) : d_c;
            conv_reg <= (f_c[W-1] ? W'(-f_c) : W'(f_c)) < W'(tol);
        end
        if (cmd.div_init)
        begin
            num_reg <= f_reg[W-1] ? W'(-f_reg) : W'(f_reg);
            neg_reg <= f_reg[W-1];
            rem_reg <= '0;
            q_reg <= '0;
            ovf_reg <= 1'b0;
            di_reg <= '0;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle over W+FracBits bits
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= W'(rem_sh - {1'b0, d_reg});
                q_reg <= {q_reg[W-2:0], 1'b1};
                if (q_reg[W-1]) ovf_reg <= 1'b1;
            end
            else
            begin
                rem_reg <= W'(rem_sh);
                q_reg <= {q_reg[W-2:0], 1'b0};
                if (q_reg[W-1]) ovf_reg <= 1'b1;
            end
            num_reg <= {num_reg[W-2:0], 1'b0};
            di_reg <= di_reg + 7'd1;
        end
        if (cmd.update)
            e_reg <= e_clamp;
        if (cmd.load || cmd.update)
        begin
            a_reg <= cmd.load ? W'(m_in) : e_clamp;
            flip_reg <= 1'b0;
        end
    end

    assign sts.reduce_done = !(a_reg > Pi) && !(a_reg < -Pi)
                             && !(a_reg > HalfPi) && !(a_reg < -HalfPi);
    assign sts.cordic_done = (ci_reg == 6'(CordicIter));
    assign sts.div_done = (di_reg == 7'(W + FracBits));
    assign sts.conv = conv_reg;

    logic [W-1:0] e_abs;
    assign e_abs = e_reg[W-1] ? W'(-e_reg) : W'(e_reg);
    assign e_out = (e_abs > W'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : e_abs[30:0];
endmodule
`default_nettype wire

@@ rtl/core/kns_ctrl.sv @@
`default_nettype none
module kns_ctrl #(
    parameter int MAX_ITERATIONS = kns_pkg::MaxIter
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output kns_pkg::cmd_t      cmd,
    input  wire kns_pkg::sts_t sts,
    output logic [5:0]         iter_out,
    output logic               conv_out
);
    import kns_pkg::*;

    state_t state_reg, state_next;
    logic [7:0] n_reg, n_next;
    logic conv_reg, conv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg <= '0;
            conv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            conv_reg <= conv_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        conv_next = conv_reg;
        cmd = '0;
        done = 1'b0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    n_next = '0;
                    conv_next = 1'b0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (sts.reduce_done)
                begin
                    cmd.cordic_init = 1'b1;
                    state_next = ST_CORDIC;
                end
                else
                    cmd.reduce = 1'b1;
            end
            ST_CORDIC:
            begin
                if (sts.cordic_done)
                begin
                    cmd.mul = 1'b1;
                    n_next = n_reg + 8'd1;
                    state_next = ST_MUL;
                end
                else
                    cmd.cordic_step = 1'b1;
            end
            ST_MUL:
            begin
                cmd.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_UPDATE;
                else
                    cmd.div_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.conv)
                begin
                    conv_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (n_reg >= 8'(MAX_ITERATIONS))
                    state_next = ST_DONE;
                else
                    state_next = ST_REDUCE;
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign iter_out = (n_reg > 8'd63) ? 6'd63 : n_reg[5:0];
    assign conv_out = conv_reg;
endmodule
`default_nettype wire

@@ rtl/core/kns_checker.sv @@
`default_nettype none
module kns_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [5:0] iterations_used
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    a_iter: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> iterations_used != 6'd0) else $error("zero iterations");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("transaction not taken");
endmodule
bind kepler_newton_solver_top kns_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .iterations_used(iterations_used)
);
`default_nettype wire
